// ===== src/ompf_pkg.sv =====
// ----------------------------------------------------------------------------
// ompf_pkg
// shared constants, gray weights and types of the oil-paint mode filter
// ----------------------------------------------------------------------------
package ompf_pkg;

    localparam int RADIUS    = 3;
    localparam int WIN       = 2 * RADIUS + 1;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int BINS      = 256;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(WIN);
    localparam int LS_DEPTH = WIN * MAX_WIDTH;
    localparam int LS_AW  = $clog2(LS_DEPTH);
    localparam int BIN_W  = $clog2(BINS);
    localparam int CNT_W  = $clog2(WIN * WIN + 1);
    localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
    localparam int Q_W    = 8;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int COARSE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [COARSE_W-1:0] COARSE_RST = 8'd110;

    localparam logic [13:0] GR_R = 14'd4899;
    localparam logic [13:0] GR_G = 14'd9617;
    localparam logic [13:0] GR_B = 14'd1868;
    localparam logic [21:0] GR_RND = 22'd8192;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sr;
        logic [SUM_W-1:0] sg;
        logic [SUM_W-1:0] sb;
    } bin_entry_t;

    typedef struct packed {
        logic             clear;
        logic             valid;
        logic             last;
        logic [BIN_W-1:0] bin;
        pixel_t           pix;
    } hist_req_t;

    typedef struct packed {
        logic       done;
        bin_entry_t best;
    } hist_res_t;

endpackage

// ===== src/ompf_line_store.sv =====
// ----------------------------------------------------------------------------
// ompf_line_store
// line buffer memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ompf_line_store
    import ompf_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [LS_AW-1:0] wr_addr,
    input  pixel_t           wr_data,
    input  logic             rd_en,
    input  logic [LS_AW-1:0] rd_addr,
    output pixel_t           rd_data
);

    pixel_t mem [LS_DEPTH];
    pixel_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== src/ompf_hist.sv =====
// ----------------------------------------------------------------------------
// ompf_hist
// per-window bin memory with read-modify-write, forwarding and running mode
// ----------------------------------------------------------------------------
module ompf_hist
    import ompf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hist_req_t req,
    output hist_res_t res
);

    bin_entry_t mem [BINS];
    bin_entry_t rd_reg;

    logic [BINS-1:0]  vld_reg;
    logic             d_v_reg;
    logic             d_last_reg;
    logic [BIN_W-1:0] d_bin_reg;
    pixel_t           d_pix_reg;
    logic             fwd_v_reg;
    logic [BIN_W-1:0] fwd_bin_reg;
    bin_entry_t       fwd_data_reg;
    bin_entry_t       best_reg;
    logic [BIN_W-1:0] best_bin_reg;

    bin_entry_t base;
    bin_entry_t upd;
    logic       take;

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rd_reg <= mem[req.bin];
        end
        if (d_v_reg)
        begin
            mem[d_bin_reg] <= upd;
        end
    end

    always_comb
    begin
        if (fwd_v_reg && fwd_bin_reg == d_bin_reg)
        begin
            base = fwd_data_reg;
        end
        else if (vld_reg[d_bin_reg])
        begin
            base = rd_reg;
        end
        else
        begin
            base = '0;
        end
        upd.cnt = base.cnt + CNT_W'(1);
        upd.sr  = base.sr + SUM_W'(d_pix_reg.red);
        upd.sg  = base.sg + SUM_W'(d_pix_reg.green);
        upd.sb  = base.sb + SUM_W'(d_pix_reg.blue);
        take = (upd.cnt > best_reg.cnt)
            || (upd.cnt == best_reg.cnt && d_bin_reg < best_bin_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            d_v_reg      <= 1'b0;
            d_last_reg   <= 1'b0;
            fwd_v_reg    <= 1'b0;
            best_reg     <= '0;
            best_bin_reg <= '0;
        end
        else if (req.clear)
        begin
            vld_reg      <= '0;
            d_v_reg      <= 1'b0;
            d_last_reg   <= 1'b0;
            fwd_v_reg    <= 1'b0;
            best_reg     <= '0;
            best_bin_reg <= '0;
        end
        else
        begin
            d_v_reg    <= req.valid;
            d_last_reg <= req.valid && req.last;
            if (d_v_reg)
            begin
                vld_reg[d_bin_reg] <= 1'b1;
                fwd_v_reg <= 1'b1;
                if (take)
                begin
                    best_reg     <= upd;
                    best_bin_reg <= d_bin_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_bin_reg <= req.bin;
        d_pix_reg <= req.pix;
        if (d_v_reg)
        begin
            fwd_bin_reg  <= d_bin_reg;
            fwd_data_reg <= upd;
        end
    end

    assign res.done = d_v_reg && d_last_reg;
    assign res.best = best_reg;

endmodule

// ===== src/ompf_divider.sv =====
// ----------------------------------------------------------------------------
// ompf_divider
// three-lane restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ompf_divider
    import ompf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  bin_entry_t best,
    output logic       done,
    output pixel_t     quot
);

    logic             busy_reg;
    logic             done_reg;
    logic [2:0]       step_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] rem_reg [3];
    logic [Q_W-1:0]   q_reg [3];

    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] rem_next [3];
    logic             bit_next [3];

    always_comb
    begin
        trial = SUM_W'(cnt_reg) << step_reg;
        for (int i = 0; i < 3; i++)
        begin
            bit_next[i] = rem_reg[i] >= trial;
            rem_next[i] = bit_next[i] ? rem_reg[i] - trial : rem_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd7;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg    <= (best.cnt == '0) ? CNT_W'(1) : best.cnt;
            rem_reg[0] <= best.sr;
            rem_reg[1] <= best.sg;
            rem_reg[2] <= best.sb;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i]           <= rem_next[i];
                q_reg[i][step_reg]   <= bit_next[i];
            end
        end
    end

    assign done       = done_reg;
    assign quot.red   = q_reg[0];
    assign quot.green = q_reg[1];
    assign quot.blue  = q_reg[2];

endmodule

// ===== src/oil_paint_mode_filter_unit.sv =====
// ----------------------------------------------------------------------------
// oil_paint_mode_filter_unit
// oil-paint mode filter over a 7x7 window on a raster RGB stream
// ----------------------------------------------------------------------------
// Pixels enter in raster order; once a full 7x7 window exists, each pixel
// yields one result for the center three rows up and three columns left: the
// mean color of the most populated intensity bin (lowest bin on ties). Border
// pixels give no result. A border pixel does not hold the input; an interior
// pixel holds the input through 49 window reads from the single read port of
// the line store, the gray, bin and bin read-modify-write pipeline, the start
// of the divider, bit-serial division, and the hand-off of the result to the
// output register and the return to idle. The result register lets the next
// pixel in while a result waits. Any configuration write restarts the frame
// at row 0.
module oil_paint_mode_filter_unit
    import ompf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COARSE_W-1:0] coarse_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [SLOT_W-1:0]   slot_reg;

    logic                iss_reg;
    logic [2:0]          dx_reg;
    logic [2:0]          dy_reg;
    logic [SLOT_W-1:0]   iss_slot_reg;
    logic [COL_W-1:0]    base_col_reg;
    logic                fe_reg;

    logic                a_v_reg, a_last_reg;
    logic                g_v_reg, g_last_reg;
    logic [7:0]          gray_reg;
    pixel_t              g_pix_reg;
    logic                b_v_reg, b_last_reg;
    logic [BIN_W-1:0]    bin_reg;
    pixel_t              b_pix_reg;
    logic                div_start_reg;

    logic                m_tvalid_reg;
    pixel_t              m_data_reg;
    logic                m_tlast_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    col_eff;
    logic [ROW_W-1:0]    row_eff;
    logic [SLOT_W-1:0]   slot_eff;
    logic                accept;
    logic                interior;
    logic                iss_last;
    pixel_t              in_pix;
    pixel_t              ls_rdata;
    logic [LS_AW-1:0]    rd_addr;
    logic [LS_AW-1:0]    wr_addr;
    logic [21:0]         gsum;
    logic [15:0]         prod;
    logic [16:0]         qsum;
    hist_req_t           hreq;
    hist_res_t           hres;
    logic                div_done;
    pixel_t              quot;
    logic                out_free;

    assign in_pix = s_tdata;
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (width_reg < WIDTH_W'(WIN))
            w_eff = WIDTH_W'(WIN);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < HEIGHT_W'(WIN))
            h_eff = HEIGHT_W'(WIN);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        col_eff  = (WIDTH_W'(col_reg) >= w_eff) ? '0 : col_reg;
        row_eff  = (HEIGHT_W'(row_reg) >= h_eff) ? '0 : row_reg;
        slot_eff = (HEIGHT_W'(row_reg) >= h_eff) ? '0 : slot_reg;
        interior = (row_eff >= ROW_W'(2 * RADIUS)) && (col_eff >= COL_W'(2 * RADIUS));
    end

    assign wr_addr  = LS_AW'(slot_eff) * LS_AW'(MAX_WIDTH) + LS_AW'(col_eff);
    assign rd_addr  = LS_AW'(iss_slot_reg) * LS_AW'(MAX_WIDTH)
                    + LS_AW'(base_col_reg + COL_W'(dx_reg));
    assign iss_last = (dx_reg == 3'(WIN - 1)) && (dy_reg == 3'(WIN - 1));

    ompf_line_store u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (in_pix),
        .rd_en   (iss_reg),
        .rd_addr (rd_addr),
        .rd_data (ls_rdata)
    );

    // positions and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            coarse_reg <= COARSE_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_COARSE: coarse_reg <= cfg_data[COARSE_W-1:0];
                default:    ;
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            if (WIDTH_W'(col_eff) + WIDTH_W'(1) >= w_eff)
            begin
                col_reg <= '0;
                if (HEIGHT_W'(row_eff) + HEIGHT_W'(1) >= h_eff)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_eff + ROW_W'(1);
                    slot_reg <= (slot_eff == SLOT_W'(WIN - 1)) ? '0 : slot_eff + SLOT_W'(1);
                end
            end
            else
            begin
                col_reg <= col_eff + COL_W'(1);
                row_reg <= row_eff;
                slot_reg <= slot_eff;
            end
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && interior) state_next = ST_RUN;
            ST_RUN:  if (hres.done) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            a_v_reg       <= 1'b0;
            a_last_reg    <= 1'b0;
            g_v_reg       <= 1'b0;
            g_last_reg    <= 1'b0;
            b_v_reg       <= 1'b0;
            b_last_reg    <= 1'b0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= hres.done;
            a_v_reg       <= iss_reg;
            a_last_reg    <= iss_reg && iss_last;
            g_v_reg       <= a_v_reg;
            g_last_reg    <= a_last_reg;
            b_v_reg       <= g_v_reg;
            b_last_reg    <= g_last_reg;
            if (state_reg == ST_IDLE && accept && interior)
            begin
                iss_reg <= 1'b1;
                dx_reg  <= '0;
                dy_reg  <= '0;
            end
            else if (iss_reg)
            begin
                if (dx_reg == 3'(WIN - 1))
                begin
                    dx_reg <= '0;
                    dy_reg <= dy_reg + 3'd1;
                    if (iss_last)
                        iss_reg <= 1'b0;
                end
                else
                begin
                    dx_reg <= dx_reg + 3'd1;
                end
            end
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_OUT && out_free)
                m_tvalid_reg <= 1'b1;
        end
    end

    // window addressing, gray and bin stages, output register
    always_comb
    begin
        gsum = GR_R * 22'(ls_rdata.red) + GR_G * 22'(ls_rdata.green)
             + GR_B * 22'(ls_rdata.blue) + GR_RND;
        prod = 16'(coarse_reg) * 16'(gray_reg);
        qsum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && interior)
        begin
            iss_slot_reg <= (slot_eff == SLOT_W'(WIN - 1)) ? '0 : slot_eff + SLOT_W'(1);
            base_col_reg <= col_eff - COL_W'(2 * RADIUS);
            fe_reg       <= (HEIGHT_W'(row_eff) == h_eff - HEIGHT_W'(1))
                         && (WIDTH_W'(col_eff) == w_eff - WIDTH_W'(1));
        end
        else if (iss_reg && dx_reg == 3'(WIN - 1))
        begin
            iss_slot_reg <= (iss_slot_reg == SLOT_W'(WIN - 1)) ? '0 : iss_slot_reg + SLOT_W'(1);
        end
        gray_reg  <= gsum[21:14];
        g_pix_reg <= ls_rdata;
        bin_reg   <= qsum[15:8];
        b_pix_reg <= g_pix_reg;
        if (state_reg == ST_OUT && out_free)
        begin
            m_data_reg  <= quot;
            m_tlast_reg <= fe_reg;
        end
    end

    assign hreq.clear = state_reg == ST_IDLE && accept && interior;
    assign hreq.valid = b_v_reg;
    assign hreq.last  = b_last_reg;
    assign hreq.bin   = bin_reg;
    assign hreq.pix   = b_pix_reg;

    ompf_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .res   (hres)
    );

    ompf_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .best  (hres.best),
        .done  (div_done),
        .quot  (quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
